### hw/rtl/svm_pkg.sv
// Package for the sample voice mixer: sizes, operation codes, sequencer states.
// No dependencies; imported by svm_mul, the mixer top level and its testbench.
package svm_pkg;

  localparam int unsigned VOICES        = 16;
  localparam int unsigned SAMPLE_FRAMES = 65536;
  localparam int unsigned VIDX_W        = $clog2(VOICES);
  localparam int unsigned ADDR_W        = $clog2(SAMPLE_FRAMES);
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned POS_W         = 33;
  localparam int unsigned FC_W          = 48;
  localparam int unsigned ACC_W         = 54;
  localparam int unsigned MUL_A_W       = 34;
  localparam int unsigned MUL_B_W       = 17;
  localparam int unsigned MUL_P_W       = MUL_A_W + MUL_B_W;
  localparam logic [23:0] SPEED_ONE     = 24'h010000;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TRIG  = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_ASCAN = 14'b00000000000010,
    ST_AWR   = 14'b00000000000100,
    ST_TCHK  = 14'b00000000001000,
    ST_TRDA  = 14'b00000000010000,
    ST_TRDB  = 14'b00000000100000,
    ST_TDL   = 14'b00000001000000,
    ST_TDR   = 14'b00000010000000,
    ST_TVL   = 14'b00000100000000,
    ST_TVR   = 14'b00001000000000,
    ST_TPL   = 14'b00010000000000,
    ST_TPR   = 14'b00100000000000,
    ST_TACC  = 14'b01000000000000,
    ST_TOUT  = 14'b10000000000000
  } state_e;

endpackage

### hw/rtl/svm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module svm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/svm_mul.sv
// Shared signed multiplier with registered product.
// Depends on svm_pkg for operand widths.
module svm_mul (
  input  logic                                clk_i,
  input  logic signed [svm_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [svm_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [svm_pkg::MUL_P_W-1:0]  p_o
);
  import svm_pkg::*;

  logic signed [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

### hw/rtl/sample_voice_mixer_top.sv
// Top level of the polyphonic stereo sample voice mixer.
// Depends on svm_pkg, svm_ram (sample memory) and svm_mul (shared multiplier).
//
//  channel   direction  handshake                 payload
//  request   in         start & !busy             operation_i .. speed_i
//  result    out        valid_o (one cycle)       mix_left_o, mix_right_o,
//                                                 active_count_o, clipped_o
//
// A sample write is taken in the accept cycle and never raises busy. A trigger
// scans the voice slots one per cycle. A tick walks every slot: an idle, not
// yet due or ending slot is only checked; a sounding slot steps through read,
// interpolate, gain, pan and accumulate states on the shared multiplier, and a
// final state forms the frame; the result strobes in the first cycle with busy
// low. Reset clears the voice active bits, frame counter and sequencer only;
// the sample memory is undefined until written. The receiver cannot stall.
module sample_voice_mixer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation_i,
  input  logic [15:0]        address_i,
  input  logic signed [15:0] left_in_i,
  input  logic signed [15:0] right_in_i,
  input  logic [16:0]        length_i,
  input  logic [23:0]        delay_frames_i,
  input  logic [15:0]        gain_i,
  input  logic [15:0]        pan_left_i,
  input  logic [15:0]        pan_right_i,
  input  logic [23:0]        speed_i,
  output logic               valid_o,
  output logic signed [15:0] mix_left_o,
  output logic signed [15:0] mix_right_o,
  output logic [4:0]         active_count_o,
  output logic               clipped_o
);
  import svm_pkg::*;

  localparam logic [VIDX_W-1:0] LAST_V = VIDX_W'(VOICES - 1);

  // Sequencer
  state_e            state_q;
  logic [VIDX_W-1:0] v_q;
  logic              accept;

  // Latched trigger request
  logic [15:0] rq_addr_q;
  logic [16:0] rq_len_q;
  logic [23:0] rq_delay_q;
  logic [15:0] rq_gain_q;
  logic [15:0] rq_panl_q;
  logic [15:0] rq_panr_q;
  logic [23:0] rq_speed_q;

  // Voice table: one entry per slot, read at the sequencer's slot index
  logic [VOICES-1:0] active_q;
  logic [15:0]       base_q  [VOICES];
  logic [16:0]       len_q   [VOICES];
  logic [POS_W-1:0]  pos_q   [VOICES];
  logic [15:0]       gain_q  [VOICES];
  logic [15:0]       panl_q  [VOICES];
  logic [15:0]       panr_q  [VOICES];
  logic [23:0]       speed_q [VOICES];
  logic [FC_W-1:0]   vstart_q[VOICES];
  logic [FC_W-1:0]   fc_q;

  // Allocation scan
  logic [VIDX_W-1:0] chosen_q;
  logic [FC_W-1:0]   oldest_q;
  logic              seen_q;

  // Datapath registers
  logic [31:0]              samp_a_q;
  logic [31:0]              samp_b_q;
  logic signed [16:0]       vl_q, vr_q;
  logic signed [32:0]       tl_q, tr_q;
  logic signed [ACC_W-1:0]  accl_q, accr_q;

  // Result registers
  logic              valid_q;
  logic signed [15:0] mixl_q, mixr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              clip_q;

  // RAM and multiplier wires
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  // Current slot
  logic [POS_W-1:0]  cur_pos;
  logic [POS_W-1:0]  limit;
  logic              due;
  logic [ADDR_W-1:0] idx_addr;
  logic signed [16:0] diff_l, diff_r;
  logic signed [MUL_P_W-1:0] rnd;
  logic [POS_W:0]    pos_sum;
  logic [POS_W-1:0]  pos_next;
  logic signed [ACC_W-1:0] sum_l, sum_r;
  logic signed [ACC_W-28:0] shl, shr;
  logic signed [15:0] satl, satr;
  logic              clipl, clipr;
  logic              better;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign ram_we = accept && (op_e'(operation_i) == OP_WRITE);

  assign cur_pos  = pos_q[v_q];
  assign limit    = (len_q[v_q] == 17'd0) ? '0 : {len_q[v_q] - 17'd1, 16'd0};
  assign due      = active_q[v_q] && (vstart_q[v_q] <= fc_q);
  assign idx_addr = base_q[v_q][ADDR_W-1:0] + cur_pos[ADDR_W+15:16];

  // Address the first frame while checking, the next one once the first is held
  always_comb begin
    if (state_q == ST_TRDB) begin
      ram_raddr = idx_addr + ADDR_W'(1);
    end else begin
      ram_raddr = idx_addr;
    end
  end

  assign diff_l = $signed({ram_rdata[15], ram_rdata[15:0]})
                - $signed({samp_a_q[15], samp_a_q[15:0]});
  assign diff_r = $signed({samp_b_q[31], samp_b_q[31:16]})
                - $signed({samp_a_q[31], samp_a_q[31:16]});

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_TDL: begin
        mul_a = MUL_A_W'(diff_l);
        mul_b = $signed({1'b0, cur_pos[15:0]});
      end
      ST_TDR: begin
        mul_a = MUL_A_W'(diff_r);
        mul_b = $signed({1'b0, cur_pos[15:0]});
      end
      ST_TVL: begin
        mul_a = MUL_A_W'(vl_q);
        mul_b = $signed({1'b0, gain_q[v_q]});
      end
      ST_TVR: begin
        mul_a = MUL_A_W'(vr_q);
        mul_b = $signed({1'b0, gain_q[v_q]});
      end
      ST_TPL: begin
        mul_a = MUL_A_W'(tl_q);
        mul_b = $signed({1'b0, panl_q[v_q]});
      end
      ST_TPR: begin
        mul_a = MUL_A_W'(tr_q);
        mul_b = $signed({1'b0, panr_q[v_q]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Round the interpolation product to nearest, ties upward
  assign rnd = (prod + MUL_P_W'(32768)) >>> 16;

  // Advance position, saturate on overflow
  assign pos_sum  = {1'b0, cur_pos} + (POS_W + 1)'(speed_q[v_q]);
  assign pos_next = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];

  // Output rounding and saturation
  assign sum_l = accl_q + ACC_W'(64'sd67108864);
  assign sum_r = accr_q + ACC_W'(64'sd67108864);
  assign shl   = sum_l[ACC_W-1:27];
  assign shr   = sum_r[ACC_W-1:27];
  always_comb begin
    clipl = 1'b0;
    clipr = 1'b0;
    satl  = shl[15:0];
    satr  = shr[15:0];
    if (shl > (ACC_W - 27)'(32767)) begin
      satl = 16'sh7fff; clipl = 1'b1;
    end else if (shl < -(ACC_W - 27)'(32768)) begin
      satl = 16'sh8000; clipl = 1'b1;
    end
    if (shr > (ACC_W - 27)'(32767)) begin
      satr = 16'sh7fff; clipr = 1'b1;
    end else if (shr < -(ACC_W - 27)'(32768)) begin
      satr = 16'sh8000; clipr = 1'b1;
    end
  end

  assign better = !seen_q || (vstart_q[v_q] < oldest_q);

  // Sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      v_q      <= '0;
      active_q <= '0;
      fc_q     <= '0;
      valid_q  <= 1'b0;
      seen_q   <= 1'b0;
      chosen_q <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            v_q      <= '0;
            seen_q   <= 1'b0;
            chosen_q <= '0;
            case (op_e'(operation_i))
              OP_TRIG: state_q <= ST_ASCAN;
              OP_TICK: state_q <= ST_TCHK;
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_ASCAN: begin
          // Take the first idle slot, else track the oldest start
          if (!active_q[v_q]) begin
            chosen_q <= v_q;
            state_q  <= ST_AWR;
          end else begin
            if (better) begin
              chosen_q <= v_q;
              seen_q   <= 1'b1;
            end
            if (v_q == LAST_V) begin
              state_q <= ST_AWR;
            end else begin
              v_q <= v_q + VIDX_W'(1);
            end
          end
        end
        ST_AWR: begin
          active_q[chosen_q] <= 1'b1;
          state_q            <= ST_IDLE;
        end
        ST_TCHK: begin
          if (due && (cur_pos < limit)) begin
            state_q <= ST_TRDA;
          end else begin
            if (due) begin
              active_q[v_q] <= 1'b0;
            end
            if (v_q == LAST_V) begin
              state_q <= ST_TOUT;
            end else begin
              v_q <= v_q + VIDX_W'(1);
            end
          end
        end
        ST_TRDA: state_q <= ST_TRDB;
        ST_TRDB: state_q <= ST_TDL;
        ST_TDL:  state_q <= ST_TDR;
        ST_TDR:  state_q <= ST_TVL;
        ST_TVL:  state_q <= ST_TVR;
        ST_TVR:  state_q <= ST_TPL;
        ST_TPL:  state_q <= ST_TPR;
        ST_TPR:  state_q <= ST_TACC;
        ST_TACC: begin
          if (v_q == LAST_V) begin
            state_q <= ST_TOUT;
          end else begin
            v_q     <= v_q + VIDX_W'(1);
            state_q <= ST_TCHK;
          end
        end
        ST_TOUT: begin
          valid_q <= 1'b1;
          fc_q    <= fc_q + FC_W'(1);
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers: request latch, voice fields, datapath and result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rq_addr_q  <= address_i;
      rq_len_q   <= length_i;
      rq_delay_q <= delay_frames_i;
      rq_gain_q  <= gain_i;
      rq_panl_q  <= pan_left_i;
      rq_panr_q  <= pan_right_i;
      rq_speed_q <= speed_i;
      accl_q     <= '0;
      accr_q     <= '0;
    end
    if (state_q == ST_ASCAN && better) begin
      oldest_q <= vstart_q[v_q];
    end
    if (state_q == ST_AWR) begin
      base_q[chosen_q]   <= rq_addr_q;
      len_q[chosen_q]    <= rq_len_q;
      pos_q[chosen_q]    <= '0;
      gain_q[chosen_q]   <= rq_gain_q;
      panl_q[chosen_q]   <= rq_panl_q;
      panr_q[chosen_q]   <= rq_panr_q;
      speed_q[chosen_q]  <= (rq_speed_q == 24'd0) ? SPEED_ONE : rq_speed_q;
      vstart_q[chosen_q] <= fc_q + FC_W'(rq_delay_q);
    end
    case (state_q)
      ST_TRDB: samp_a_q <= ram_rdata;
      ST_TDL:  samp_b_q <= ram_rdata;
      ST_TDR:  vl_q <= $signed({samp_a_q[15], samp_a_q[15:0]}) + rnd[16:0];
      ST_TVL:  vr_q <= $signed({samp_a_q[31], samp_a_q[31:16]}) + rnd[16:0];
      ST_TVR:  tl_q <= prod[32:0];
      ST_TPL:  tr_q <= prod[32:0];
      ST_TPR:  accl_q <= accl_q + ACC_W'(prod);
      ST_TACC: begin
        accr_q       <= accr_q + ACC_W'(prod);
        pos_q[v_q]   <= pos_next;
      end
      ST_TOUT: begin
        mixl_q <= satl;
        mixr_q <= satr;
        clip_q <= clipl || clipr;
        cnt_q  <= CNT_W'($countones(active_q));
      end
      default: begin
      end
    endcase
  end

  svm_ram #(
    .WIDTH(32),
    .DEPTH(SAMPLE_FRAMES)
  ) u_samples (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(address_i[ADDR_W-1:0]),
    .wdata_i({right_in_i, left_in_i}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  svm_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  assign valid_o        = valid_q;
  assign mix_left_o     = mixl_q;
  assign mix_right_o    = mixr_q;
  assign active_count_o = cnt_q;
  assign clipped_o      = clip_q;

`ifndef SYNTHESIS
  a_valid_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == ST_TOUT))
    else $error("result strobe without frame completion");
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == OP_TICK) |=> (busy && v_q == '0))
    else $error("tick did not start the slot walk at slot zero");
  a_fc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (fc_q == $past(fc_q) + FC_W'(1)))
    else $error("frame counter did not advance with the result");
`endif

endmodule

### verif/tb_sample_voice_mixer_top.sv
// Self-checking testbench for sample_voice_mixer_top: random and directed
// requests, a behavioural mixer predictor and a frame scoreboard.
// Depends on svm_pkg and the mixer RTL only.
`timescale 1ns / 1ps

module tb_sample_voice_mixer_top;
  import svm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam logic [32:0] POS_SAT = 33'h1FFFFFFFF;
  localparam logic [47:0] FC_MASK = 48'hFFFFFFFFFFFF;
  // Written window of the sample memory; it wraps past the top address
  localparam logic [15:0] WIN_LO = 16'hFF80;
  localparam int WIN_FRAMES = 256;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [15:0] left;
    logic [15:0] right;
    logic [16:0] len;
    logic [23:0] dly;
    logic [15:0] gain;
    logic [15:0] pan_l;
    logic [15:0] pan_r;
    logic [23:0] spd;
    int          gap;
  } request_t;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic [4:0]  count;
    logic        clip;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0]         operation_i = '0;
  logic [15:0]        address_i = '0;
  logic signed [15:0] left_in_i = '0;
  logic signed [15:0] right_in_i = '0;
  logic [16:0]        length_i = '0;
  logic [23:0]        delay_frames_i = '0;
  logic [15:0]        gain_i = '0;
  logic [15:0]        pan_left_i = '0;
  logic [15:0]        pan_right_i = '0;
  logic [23:0]        speed_i = '0;
  logic               valid_o;
  logic signed [15:0] mix_left_o;
  logic signed [15:0] mix_right_o;
  logic [4:0]         active_count_o;
  logic               clipped_o;

  sample_voice_mixer_top u_dut (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .address_i, .left_in_i,
    .right_in_i, .length_i, .delay_frames_i, .gain_i, .pan_left_i,
    .pan_right_i, .speed_i, .valid_o, .mix_left_o, .mix_right_o,
    .active_count_o, .clipped_o
  );

  always #5 clk_i = ~clk_i;

  // Predictor copy of the mixer state
  logic [31:0] sample_mem [SAMPLE_FRAMES];
  logic        vc_on    [VOICES];
  logic [15:0] vc_base  [VOICES];
  logic [16:0] vc_len   [VOICES];
  logic [32:0] vc_pos   [VOICES];
  logic [15:0] vc_gain  [VOICES];
  logic [15:0] vc_pan_l [VOICES];
  logic [15:0] vc_pan_r [VOICES];
  logic [23:0] vc_spd   [VOICES];
  logic [47:0] vc_due   [VOICES];
  logic [47:0] frame_no = '0;

  request_t pending_q[$];
  frame_t   frame_q[$];
  request_t cur_req, next_req;
  bit       staged = 1'b0;
  int       gap_left = 0;
  int       mismatches = 0;
  int       frames_seen = 0, clipped_seen = 0;
  int       n_writes = 0, n_trigs = 0, n_ticks = 0, n_ignored = 0;
  longint   cycles = 0;

  // Append a request to the driver's queue
  task automatic queue_req(request_t r);
    pending_q.insert(pending_q.size(), r);
  endtask

  // Interpolate one channel: s0 + floor(((s1 - s0) * f + 32768) / 65536)
  function automatic longint lerp_channel(logic [15:0] a, logic [15:0] b,
                                          logic [15:0] f);
    longint s0, s1;
    s0 = longint'($signed(a));
    s1 = longint'($signed(b));
    return s0 + (((s1 - s0) * longint'(f) + 32768) >>> 16);
  endfunction

  function automatic logic [15:0] round_sat(longint acc, inout logic clip);
    longint v;
    v = (acc + (longint'(1) << 26)) >>> 27;
    if (v > 32767) begin
      clip = 1'b1;
      return 16'h7FFF;
    end
    if (v < -32768) begin
      clip = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  task automatic mix_apply(request_t r);
    int slot;
    logic [63:0] oldest;
    longint accl, accr, vl, vr;
    logic [32:0] lim;
    logic [33:0] npos;
    logic [15:0] idx;
    logic [31:0] wa, wb;
    frame_t fr;
    int cnt;
    case (r.op)
      OP_WRITE: begin
        sample_mem[r.addr] = {r.right, r.left};
        n_writes++;
      end
      OP_TRIG: begin
        slot = 0;
        oldest = '1;
        for (int i = 0; i < VOICES; i++) begin
          if (!vc_on[i]) begin
            slot = i;
            break;
          end
          if (64'(vc_due[i]) < oldest) begin
            oldest = 64'(vc_due[i]);
            slot = i;
          end
        end
        vc_base[slot]  = r.addr;
        vc_len[slot]   = r.len;
        vc_pos[slot]   = '0;
        vc_gain[slot]  = r.gain;
        vc_pan_l[slot] = r.pan_l;
        vc_pan_r[slot] = r.pan_r;
        vc_spd[slot]   = (r.spd == 0) ? SPEED_ONE : r.spd;
        vc_due[slot]   = (frame_no + 48'(r.dly)) & FC_MASK;
        vc_on[slot]    = 1'b1;
        n_trigs++;
      end
      OP_TICK: begin
        accl = 0;
        accr = 0;
        fr.clip = 1'b0;
        for (int i = 0; i < VOICES; i++) begin
          if (!vc_on[i] || vc_due[i] > frame_no) continue;
          lim = (vc_len[i] == 0) ? '0 : {33'(vc_len[i] - 17'd1)} << 16;
          if (vc_pos[i] >= lim) begin
            vc_on[i] = 1'b0;
            continue;
          end
          idx = vc_pos[i][31:16];
          wa = sample_mem[16'(vc_base[i] + idx)];
          wb = sample_mem[16'(vc_base[i] + idx + 16'd1)];
          vl = lerp_channel(wa[15:0], wb[15:0], vc_pos[i][15:0]);
          vr = lerp_channel(wa[31:16], wb[31:16], vc_pos[i][15:0]);
          accl += vl * longint'(vc_gain[i]) * longint'(vc_pan_l[i]);
          accr += vr * longint'(vc_gain[i]) * longint'(vc_pan_r[i]);
          npos = 34'(vc_pos[i]) + 34'(vc_spd[i]);
          vc_pos[i] = (npos > 34'(POS_SAT)) ? POS_SAT : npos[32:0];
        end
        cnt = 0;
        for (int i = 0; i < VOICES; i++) if (vc_on[i]) cnt++;
        fr.left  = round_sat(accl, fr.clip);
        fr.right = round_sat(accr, fr.clip);
        fr.count = 5'(cnt);
        frame_q.insert(frame_q.size(), fr);
        frame_no = (frame_no + 48'd1) & FC_MASK;
        n_ticks++;
      end
      default: n_ignored++;
    endcase
  endtask

  // Driver: a request moves on an edge with start high and busy low
  always @(posedge clk_i or negedge rst_ni) begin
    logic drive;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) mix_apply(cur_req);
      drive = start && busy;
      if (!drive) begin
        if (!staged && pending_q.size() != 0) begin
          next_req = pending_q.pop_front();
          staged = 1'b1;
          gap_left = next_req.gap;
        end
        if (staged) begin
          if (gap_left == 0) begin
            cur_req = next_req;
            staged = 1'b0;
            drive = 1'b1;
            operation_i    <= next_req.op;
            address_i      <= next_req.addr;
            left_in_i      <= next_req.left;
            right_in_i     <= next_req.right;
            length_i       <= next_req.len;
            delay_frames_i <= next_req.dly;
            gain_i         <= next_req.gain;
            pan_left_i     <= next_req.pan_l;
            pan_right_i    <= next_req.pan_r;
            speed_i        <= next_req.spd;
          end else begin
            gap_left--;
          end
        end
      end
      start <= drive;
    end
  end

  // Monitor: every strobed frame is checked against the oldest prediction
  always @(posedge clk_i) begin
    frame_t exp_fr;
    if (rst_ni && valid_o) begin
      frames_seen++;
      if (clipped_o) clipped_seen++;
      if (frame_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected frame L=%0d R=%0d", mix_left_o, mix_right_o);
      end else begin
        exp_fr = frame_q.pop_front();
        if (mix_left_o !== exp_fr.left || mix_right_o !== exp_fr.right ||
            active_count_o !== exp_fr.count || clipped_o !== exp_fr.clip) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: frame %0d exp L=%0d R=%0d n=%0d c=%0b got L=%0d R=%0d n=%0d c=%0b",
                     frames_seen, $signed(exp_fr.left), $signed(exp_fr.right),
                     exp_fr.count, exp_fr.clip, mix_left_o, mix_right_o,
                     active_count_o, clipped_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic request_t blank_req(logic [1:0] op);
    request_t r;
    r.op = op;
    r.addr = $urandom();
    r.left = $urandom();
    r.right = $urandom();
    r.len = $urandom();
    r.dly = $urandom();
    r.gain = $urandom();
    r.pan_l = $urandom();
    r.pan_r = $urandom();
    r.spd = $urandom();
    r.gap = pick_gap();
    return r;
  endfunction

  function automatic request_t trig_req(logic [15:0] addr, logic [16:0] len,
                                        logic [23:0] dly, logic [15:0] gain,
                                        logic [15:0] pl, logic [15:0] pr,
                                        logic [23:0] spd);
    request_t r;
    r = blank_req(OP_TRIG);
    r.addr = addr; r.len = len; r.dly = dly; r.gain = gain;
    r.pan_l = pl; r.pan_r = pr; r.spd = spd;
    return r;
  endfunction

  // Mostly musical triggers: short samples, near-unit speeds, short delays.
  // Every frame a voice can reach lies inside the written window.
  function automatic request_t random_trig();
    request_t r;
    int p;
    int off;
    r = blank_req(OP_TRIG);
    if ($urandom_range(99) < 75) r.dly = $urandom_range(0, 6);
    if ($urandom_range(99) < 70) r.spd = $urandom_range(0, 24'h30000);
    if ($urandom_range(99) < 60) begin
      r.pan_l = $urandom_range(0, 32768);
      r.pan_r = $urandom_range(0, 32768);
    end
    p = $urandom_range(99);
    if (p < 90) begin
      if (p < 80) r.len = 17'($urandom_range(0, 48));
      else r.len = 17'($urandom_range(0, WIN_FRAMES));
      if (r.len == 0) off = $urandom_range(0, WIN_FRAMES - 1);
      else off = $urandom_range(0, WIN_FRAMES - int'(r.len));
    end else begin
      // Long or oversized sample that crawls and stays near its first frame
      r.len = 17'($urandom_range(17'h10000, 17'h1FFFF));
      r.spd = 24'($urandom_range(1, 64));
      off = $urandom_range(0, WIN_FRAMES - 4);
    end
    r.addr = WIN_LO + 16'(off);
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0 || staged || start || frame_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    request_t r;
    int p;
    for (int i = 0; i < VOICES; i++) begin
      vc_on[i] = 1'b0; vc_base[i] = '0; vc_len[i] = '0; vc_pos[i] = '0;
      vc_gain[i] = '0; vc_pan_l[i] = '0; vc_pan_r[i] = '0; vc_spd[i] = '0;
      vc_due[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill the sample window; triggers only reach frames inside it
    for (int k = 0; k < WIN_FRAMES; k++) begin
      r = blank_req(OP_WRITE);
      r.addr = WIN_LO + 16'(k);
      r.gap = 0;
      if (r.addr == 16'h0000) begin r.left = 16'h7FFF; r.right = 16'h8000; end
      if (r.addr == 16'h0001) begin r.left = 16'h8000; r.right = 16'h7FFF; end
      queue_req(r);
    end

    // Directed: full-scale voices to force clipping, wrap past the top of
    // memory, zero and unit length, speed zero, maximum delay and speed,
    // out-of-range length and pan, and the unused operation
    queue_req(trig_req(16'h0000, 17'd2, 24'd0, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 24'd0));
    queue_req(trig_req(16'hFFFF, 17'd3, 24'd0, 16'hFFFF, 16'd32768,
                       16'd32768, 24'h008000));
    queue_req(trig_req(16'h1234, 17'd0, 24'd0, 16'h1000, 16'd0,
                       16'd0, 24'd0));
    queue_req(trig_req(16'h4321, 17'd1, 24'd1, 16'h1000, 16'd16384,
                       16'd16384, 24'd0));
    queue_req(trig_req(16'h0010, 17'h1FFFF, 24'd0, 16'h0001, 16'd1,
                       16'd65535, 24'd1));
    queue_req(trig_req(16'h0020, 17'd3, 24'd0, 16'h3000, 16'd20000,
                       16'd9000, 24'hFFFFFF));
    queue_req(trig_req(16'hF000, 17'h10000, 24'hFFFFFF, 16'h2000,
                       16'd32768, 16'd0, 24'h000001));
    r = blank_req(OP_UNUSED);
    queue_req(r);
    for (int k = 0; k < 6; k++) queue_req(blank_req(OP_TICK));
    // A burst of random triggers, then more ticks
    for (int k = 0; k < 12; k++) queue_req(random_trig());
    for (int k = 0; k < 4; k++) queue_req(blank_req(OP_TICK));
    wait_drained();

    // Random traffic
    for (int k = 0; k < 420; k++) begin
      p = $urandom_range(99);
      if (p < 25) queue_req(blank_req(OP_WRITE));
      else if (p < 50) queue_req(random_trig());
      else if (p < 96) queue_req(blank_req(OP_TICK));
      else queue_req(blank_req(OP_UNUSED));
    end
    wait_drained();

    if (frame_q.size() != 0) mismatches += frame_q.size();
    $display("Covered %0d writes, %0d triggers, %0d ticks, %0d ignored requests;",
             n_writes, n_trigs, n_ticks, n_ignored);
    $display("checked %0d frames, %0d of them clipped.", frames_seen, clipped_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
